/* sv/lcs_pkg.sv */
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants for the longest-common-subsequence block.
// ----------------------------------------------------------------------------
`default_nettype none

package lcs_pkg;

  localparam int LEN_W       = 6;
  localparam int CHAR_W      = 8;
  localparam int MAX_LEN_DEF = 32;

  localparam logic KIND_LENGTH = 1'b0;
  localparam logic KIND_PAIR   = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0] a_char;
    logic [CHAR_W-1:0] b_char;
    logic              final_item;
  } lcs_in_t;

  typedef struct packed {
    logic             kind;
    logic [LEN_W-1:0] lcs_length;
    logic [LEN_W-1:0] a_index;
    logic [LEN_W-1:0] b_index;
    logic             overflow;
    logic             run_end;
  } lcs_out_t;

endpackage

`default_nettype wire

/* sv/lcs_score_ram.sv */
// ----------------------------------------------------------------------------
// lcs_score_ram
// Score table storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_score_ram #(
  parameter int DEPTH = 1089,
  parameter int AW    = 11,
  parameter int DW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re0,
  input  wire logic [AW-1:0] raddr0,
  output logic      [DW-1:0] rdata0,
  input  wire logic          re1,
  input  wire logic [AW-1:0] raddr1,
  output logic      [DW-1:0] rdata1
);

  logic [DW-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re0) begin
      rdata0 <= mem[raddr0];
    end
    if (re1) begin
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

/* sv/lcs_length_and_traceback.sv */
// ----------------------------------------------------------------------------
// lcs_length_and_traceback
// Loads two byte sequences, fills the LCS score table, traces back and
// reports the length and the matched index pairs in ascending order.
//
//   channel   handshake            payload
//   input     start / busy         item   (lcs_in_t)
//   output    strobe               result (lcs_out_t)
//
// Loading takes an item whenever start is high and busy is low. The final item
// starts a run on n stored pairs: table fill (one cell per cycle from the score
// RAM read port, with an S_ROW setup step before each row), traceback (per step
// an S_TB_CHK RAM read, then an S_TB_EV decision), then one result per cycle.
// busy is high for the whole run; results cannot be stalled.
// Reset is synchronous and clears control state only.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_length_and_traceback #(
  parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire lcs_pkg::lcs_in_t item,
  output logic                  strobe,
  output lcs_pkg::lcs_out_t     result
);

  import lcs_pkg::*;

  localparam int DIM = MAX_LEN + 1;
  localparam int TD  = DIM * DIM;
  localparam int TAW = $clog2(TD);
  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_LEN);
  localparam logic [CW-1:0] ONE  = CW'(1);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ROW      = 7'b0000010,
    S_FILL     = 7'b0000100,
    S_TB_CHK   = 7'b0001000,
    S_TB_EV    = 7'b0010000,
    S_OUT_LEN  = 7'b0100000,
    S_OUT_PAIR = 7'b1000000
  } state_t;

  function automatic logic [TAW-1:0] tbl_addr(input logic [CW-1:0] r,
                                              input logic [CW-1:0] c);
    return TAW'(int'(r) * DIM + int'(c));
  endfunction

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic              dropped, dropped_next;
  logic [CW-1:0]     n, n_next;
  logic [CW-1:0]     i, i_next;
  logic [CW-1:0]     j, j_next;
  logic [CW-1:0]     k, k_next;
  logic [CW-1:0]     t, t_next;
  logic [CW-1:0]     depth, depth_next;
  logic [LEN_W-1:0]  len, len_next;
  logic [LEN_W-1:0]  left, left_next;
  logic [LEN_W-1:0]  diag, diag_next;

  logic [CHAR_W-1:0] seq_a [0:MAX_LEN-1];
  logic [CHAR_W-1:0] seq_b [0:MAX_LEN-1];
  logic [2*LEN_W-1:0] stack [0:MAX_LEN-1];
  logic [CHAR_W-1:0] a_q, b_q;
  logic [2*LEN_W-1:0] s_q;

  logic              ld_we;
  logic              a_re, b_re, s_re, s_we;
  logic [IW-1:0]     a_ra, b_ra, s_ra, s_wa;
  logic [2*LEN_W-1:0] s_wd;

  logic              t_we, t_re0, t_re1;
  logic [TAW-1:0]    t_wa, t_ra0, t_ra1;
  logic [LEN_W-1:0]  t_wd, t_q0, t_q1;

  logic              accept;
  logic [CW-1:0]     n_new;
  logic [LEN_W-1:0]  up_f, v, up_tb;
  logic [CW-1:0]     im1, jm1, km1, tm1, dm1;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign ld_we  = accept && (count < MAXC);
  assign n_new  = ld_we ? count + ONE : count;
  assign im1    = i - ONE;
  assign jm1    = j - ONE;
  assign km1    = k - ONE;
  assign tm1    = t - ONE;
  assign dm1    = depth - ONE;
  assign up_f   = (i == ONE) ? '0 : t_q0;
  assign v      = (a_q == b_q) ? diag + LEN_W'(1) : ((up_f > left) ? up_f : left);
  assign up_tb  = (k == ONE) ? '0 : t_q1;

  lcs_score_ram #(
    .DEPTH (TD),
    .AW    (TAW),
    .DW    (LEN_W)
  ) u_ram (
    .clk    (clk),
    .we     (t_we),
    .waddr  (t_wa),
    .wdata  (t_wd),
    .re0    (t_re0),
    .raddr0 (t_ra0),
    .rdata0 (t_q0),
    .re1    (t_re1),
    .raddr1 (t_ra1),
    .rdata1 (t_q1)
  );

  always_comb begin
    state_next   = state;
    count_next   = count;
    dropped_next = dropped;
    n_next       = n;
    i_next       = i;
    j_next       = j;
    k_next       = k;
    t_next       = t;
    depth_next   = depth;
    len_next     = len;
    left_next    = left;
    diag_next    = diag;
    a_re  = 1'b0;
    a_ra  = '0;
    b_re  = 1'b0;
    b_ra  = '0;
    s_re  = 1'b0;
    s_ra  = '0;
    s_we  = 1'b0;
    s_wa  = depth[IW-1:0];
    s_wd  = {LEN_W'(km1), LEN_W'(tm1)};
    t_we  = 1'b0;
    t_wa  = tbl_addr(i, j);
    t_wd  = v;
    t_re0 = 1'b0;
    t_ra0 = '0;
    t_re1 = 1'b0;
    t_ra1 = '0;
    strobe = 1'b0;
    result = '0;
    result.overflow = dropped;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          count_next = n_new;
          if (!ld_we) begin
            dropped_next = 1'b1;
          end
          if (item.final_item) begin
            n_next     = n_new;
            len_next   = '0;
            depth_next = '0;
            i_next     = ONE;
            state_next = (n_new == '0) ? S_OUT_LEN : S_ROW;
          end
        end
      end
      S_ROW: begin
        a_re      = 1'b1;
        a_ra      = im1[IW-1:0];
        b_re      = 1'b1;
        b_ra      = '0;
        t_re0     = 1'b1;
        t_ra0     = tbl_addr(im1, ONE);
        j_next    = ONE;
        left_next = '0;
        diag_next = '0;
        state_next = S_FILL;
      end
      S_FILL: begin
        t_we      = 1'b1;
        left_next = v;
        diag_next = up_f;
        if (i == n && j == n) begin
          len_next = v;
        end
        if (j != n) begin
          b_re   = 1'b1;
          b_ra   = j[IW-1:0];
          t_re0  = 1'b1;
          t_ra0  = tbl_addr(im1, j + ONE);
          j_next = j + ONE;
        end else if (i != n) begin
          i_next     = i + ONE;
          state_next = S_ROW;
        end else begin
          k_next     = n;
          t_next     = n;
          state_next = S_TB_CHK;
        end
      end
      S_TB_CHK: begin
        if (k == '0 || t == '0 || depth == MAXC) begin
          state_next = S_OUT_LEN;
        end else begin
          a_re  = 1'b1;
          a_ra  = km1[IW-1:0];
          b_re  = 1'b1;
          b_ra  = tm1[IW-1:0];
          t_re0 = 1'b1;
          t_ra0 = tbl_addr(k, t);
          t_re1 = 1'b1;
          t_ra1 = tbl_addr(km1, t);
          state_next = S_TB_EV;
        end
      end
      S_TB_EV: begin
        priority if (t_q0 == '0) begin
          state_next = S_OUT_LEN;
        end else if (a_q == b_q) begin
          s_we       = 1'b1;
          depth_next = depth + ONE;
          k_next     = km1;
          t_next     = tm1;
          state_next = S_TB_CHK;
        end else if (up_tb == t_q0) begin
          k_next     = km1;
          state_next = S_TB_CHK;
        end else begin
          t_next     = tm1;
          state_next = S_TB_CHK;
        end
      end
      S_OUT_LEN, S_OUT_PAIR: begin
        strobe = 1'b1;
        if (state == S_OUT_LEN) begin
          result.kind       = KIND_LENGTH;
          result.lcs_length = len;
        end else begin
          result.kind    = KIND_PAIR;
          result.a_index = s_q[2*LEN_W-1:LEN_W];
          result.b_index = s_q[LEN_W-1:0];
        end
        result.run_end = (depth == '0);
        if (depth != '0) begin
          s_re       = 1'b1;
          s_ra       = dm1[IW-1:0];
          depth_next = dm1;
          state_next = S_OUT_PAIR;
        end else begin
          count_next   = '0;
          dropped_next = 1'b0;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      dropped <= 1'b0;
      depth   <= '0;
      n       <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
      depth   <= depth_next;
      n       <= n_next;
    end
  end

  always_ff @(posedge clk) begin
    i    <= i_next;
    j    <= j_next;
    k    <= k_next;
    t    <= t_next;
    len  <= len_next;
    left <= left_next;
    diag <= diag_next;
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      seq_a[count[IW-1:0]] <= item.a_char;
      seq_b[count[IW-1:0]] <= item.b_char;
    end
    if (a_re) begin
      a_q <= seq_a[a_ra];
    end
    if (b_re) begin
      b_q <= seq_b[b_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      stack[s_wa] <= s_wd;
    end
    if (s_re) begin
      s_q <= stack[s_ra];
    end
  end

  a_final_run_end_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && result.run_end |=> !busy)
    else $error("block still busy after final result");

  a_results_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.run_end |=> strobe)
    else $error("gap in result sequence");

  a_final_starts_run: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.final_item |=> busy)
    else $error("final item did not start a run");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !item.final_item |=> !busy && !strobe)
    else $error("non-final item left the idle state");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= n)
    else $error("match stack deeper than loaded length");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte-pair items into lcs_length_and_traceback and compares every
// result against a predictor that scores both sequences and traces back
// the matched pairs. Covers directed corner runs, full and overflowing
// loads, and randomized runs with bursty input and drain pauses.
// ----------------------------------------------------------------------------

module testbench;
  import lcs_pkg::*;

  localparam int PAIR_CAP     = MAX_LEN_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 40;
  localparam int RANDOM_ITEMS = 100;

  logic     clk   = 1'b0;
  logic     rst   = 1'b1;
  logic     start = 1'b0;
  lcs_in_t  item  = '0;
  logic     busy;
  logic     strobe;
  lcs_out_t result;

  logic [CHAR_W-1:0] seq_a [PAIR_CAP];
  logic [CHAR_W-1:0] seq_b [PAIR_CAP];
  int unsigned pairs_loaded  = 0;
  logic        pairs_dropped = 1'b0;
  lcs_out_t    expected_results [$];
  int unsigned failures    = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_count = 0;

  lcs_length_and_traceback i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .strobe(strobe),
    .result(result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic lcs_in_t make_item(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b,
                                        logic last);
    lcs_in_t it;
    it.a_char     = a;
    it.b_char     = b;
    it.final_item = last;
    return it;
  endfunction

  function automatic string fmt_result(lcs_out_t r);
    return $sformatf("kind=%0d len=%0d a=%0d b=%0d ovf=%0d end=%0d",
                     r.kind, r.lcs_length, r.a_index, r.b_index, r.overflow, r.run_end);
  endfunction

  function automatic void log_failure(string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  function automatic void emit_lcs_results();
    int unsigned score [0:PAIR_CAP][0:PAIR_CAP];
    logic [LEN_W-1:0] hit_a [PAIR_CAP];
    logic [LEN_W-1:0] hit_b [PAIR_CAP];
    int unsigned n, k, t, depth;
    lcs_out_t r;
    n = pairs_loaded;
    for (int i = 0; i <= n; i++) begin
      for (int j = 0; j <= n; j++) begin
        if (i == 0 || j == 0) begin
          score[i][j] = 0;
        end else if (seq_a[i-1] == seq_b[j-1]) begin
          score[i][j] = (score[i-1][j-1] + 1) % 64;
        end else begin
          score[i][j] = (score[i-1][j] > score[i][j-1]) ? score[i-1][j] : score[i][j-1];
        end
      end
    end
    k = n;
    t = n;
    depth = 0;
    while (k > 0 && t > 0 && score[k][t] != 0 && depth < PAIR_CAP) begin
      if (seq_a[k-1] == seq_b[t-1]) begin
        hit_a[depth] = LEN_W'(k - 1);
        hit_b[depth] = LEN_W'(t - 1);
        depth++;
        k--;
        t--;
      end else if (score[k-1][t] == score[k][t]) begin
        k--;
      end else begin
        t--;
      end
    end
    r            = '0;
    r.kind       = KIND_LENGTH;
    r.lcs_length = LEN_W'(score[n][n]);
    r.overflow   = pairs_dropped;
    r.run_end    = (depth == 0);
    expected_results.insert(expected_results.size(), r);
    while (depth > 0) begin
      depth--;
      r          = '0;
      r.kind     = KIND_PAIR;
      r.a_index  = hit_a[depth];
      r.b_index  = hit_b[depth];
      r.overflow = pairs_dropped;
      r.run_end  = (depth == 0);
      expected_results.insert(expected_results.size(), r);
    end
  endfunction

  function automatic void load_pair_item(lcs_in_t it);
    if (pairs_loaded < PAIR_CAP) begin
      seq_a[pairs_loaded] = it.a_char;
      seq_b[pairs_loaded] = it.b_char;
      pairs_loaded++;
    end else begin
      pairs_dropped = 1'b1;
    end
    if (it.final_item) begin
      emit_lcs_results();
      pairs_loaded  = 0;
      pairs_dropped = 1'b0;
    end
  endfunction

  function automatic void check_result(lcs_out_t got);
    lcs_out_t want;
    if (expected_results.size() == 0) begin
      log_failure($sformatf("unexpected result: %s", fmt_result(got)));
    end else begin
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.lcs_length !== want.lcs_length ||
          got.a_index !== want.a_index || got.b_index !== want.b_index ||
          got.overflow !== want.overflow || got.run_end !== want.run_end) begin
        log_failure($sformatf("result differs: expected %s, got %s",
                              fmt_result(want), fmt_result(got)));
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && start && !busy) load_pair_item(item);
  end

  always @(posedge clk) begin
    if (!rst && strobe) check_result(result);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lcs_length_and_traceback: mismatch");
      $finish;
    end
  end

  task automatic send_item(input lcs_in_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_run(input int unsigned len, input bit narrow);
    logic [CHAR_W-1:0] base;
    logic [CHAR_W-1:0] a, b;
    base = CHAR_W'($urandom_range(0, 255));
    for (int unsigned i = 0; i < len; i++) begin
      a = narrow ? base ^ CHAR_W'($urandom_range(0, 3)) : CHAR_W'($urandom_range(0, 255));
      b = narrow ? base ^ CHAR_W'($urandom_range(0, 3)) : CHAR_W'($urandom_range(0, 255));
      send_item(make_item(a, b, i == len - 1));
    end
  endtask

  task automatic test_directed();
    send_item(make_item(8'h00, 8'h00, 1'b1));
    send_item(make_item(8'hFF, 8'h00, 1'b1));
    send_item(make_item(8'hFF, 8'hFF, 1'b0));
    send_item(make_item(8'hAA, 8'h55, 1'b0));
    send_item(make_item(8'h55, 8'hAA, 1'b1));
    send_item(make_item(8'h61, 8'h62, 1'b0));
    send_item(make_item(8'h62, 8'h61, 1'b1));
    send_item(make_item(8'h01, 8'h02, 1'b0));
    send_item(make_item(8'h03, 8'h04, 1'b0));
    send_item(make_item(8'h05, 8'h06, 1'b1));
    send_item(make_item(8'h07, 8'h07, 1'b0));
    send_item(make_item(8'h07, 8'h07, 1'b0));
    send_item(make_item(8'h07, 8'h07, 1'b0));
    send_item(make_item(8'h07, 8'h07, 1'b1));
    send_item(make_item(8'h80, 8'h01, 1'b0));
    send_item(make_item(8'h01, 8'h80, 1'b1));
  endtask

  task automatic test_capacity();
    logic [CHAR_W-1:0] c;
    for (int i = 0; i < PAIR_CAP; i++) begin
      c = CHAR_W'($urandom_range(0, 255));
      send_item(make_item(c, c, i == PAIR_CAP - 1));
    end
    wait_for_results();
    send_run(PAIR_CAP, 1'b1);
    send_run(PAIR_CAP + 1, 1'b1);
    wait_for_results();
    send_run(PAIR_CAP + 6, 1'b0);
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = $urandom_range(1, 8);
      else if (pick < 90) len = $urandom_range(9, PAIR_CAP - 1);
      else if (pick < 97) len = PAIR_CAP;
      else                len = $urandom_range(PAIR_CAP + 1, PAIR_CAP + 4);
      send_run(len, $urandom_range(0, 4) != 0);
      sent += len;
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_for_results();
    test_capacity();
    wait_for_results();
    test_random();
    wait_for_results();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("lcs_length_and_traceback: match");
    end else begin
      $display("lcs_length_and_traceback: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/lcs_pkg.sv
sv/lcs_score_ram.sv
sv/lcs_length_and_traceback.sv
tb/testbench.sv
